@@ design/ped_pkg.sv @@
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, character constants and hex helpers for the percent-escape
// decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned MaxBytes          = 3;
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [1:0] {
    PhNone    = 2'd0,
    PhPercent = 2'd1,
    PhOneHex  = 2'd2
  } ped_phase_e;

  // What one input item releases: zero to three bytes, first in entry 0.
  typedef struct packed {
    logic [1:0]                     cnt;
    logic                           last;
    logic [MaxBytes-1:0][7:0]       bytes;
  } ped_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ped_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

@@ design/ped_front.sv @@
// ----------------------------------------------------------------------------
// ped_front
// Accepts raw bytes, tracks the escape state and turns each item into a
// bundle of zero to three decoded bytes for the queue.
// ----------------------------------------------------------------------------
module ped_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  ped_pkg::ped_qstat_t qstat_i,
  output logic                push_o,
  output ped_pkg::ped_bundle_t push_data_o
);
  import ped_pkg::*;

  logic        plus_q;
  ped_phase_e  phase_q, phase_d;
  logic [7:0]  hold_q, hold_d;
  logic        accept;
  ped_bundle_t bnd;
  logic [1:0]  n;
  logic        b_hex;
  logic        plain_start;
  logic [7:0]  plain_byte;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign b_hex      = is_hex(in_byte_i);

  // Decoding of the current byte with no escape pending.
  assign plain_start = (in_byte_i == ChPercent);
  assign plain_byte  = ((in_byte_i == ChPlus) && plus_q) ? ChSpace : in_byte_i;

  always_comb begin
    n       = 2'd0;
    bnd     = '0;
    phase_d = phase_q;
    hold_d  = hold_q;
    case (phase_q)
      PhPercent: begin
        if (b_hex) begin
          phase_d = PhOneHex;
          hold_d  = in_byte_i;
        end else begin
          bnd.bytes[n] = ChPercent;
          n = n + 2'd1;
          phase_d = plain_start ? PhPercent : PhNone;
          if (!plain_start) begin
            bnd.bytes[n] = plain_byte;
            n = n + 2'd1;
          end
        end
      end
      PhOneHex: begin
        if (b_hex) begin
          phase_d = PhNone;
          bnd.bytes[n] = {hex_val(hold_q), hex_val(in_byte_i)};
          n = n + 2'd1;
        end else begin
          bnd.bytes[n] = ChPercent;
          n = n + 2'd1;
          bnd.bytes[n] = hold_q;
          n = n + 2'd1;
          phase_d = plain_start ? PhPercent : PhNone;
          if (!plain_start) begin
            bnd.bytes[n] = plain_byte;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        phase_d = plain_start ? PhPercent : PhNone;
        if (!plain_start) begin
          bnd.bytes[n] = plain_byte;
          n = n + 2'd1;
        end
      end
    endcase

    // The end of the string flushes a pending escape literally.
    if (in_last_i) begin
      if (phase_d == PhPercent) begin
        bnd.bytes[n] = ChPercent;
        n = n + 2'd1;
      end else if (phase_d == PhOneHex) begin
        bnd.bytes[n] = ChPercent;
        n = n + 2'd1;
        bnd.bytes[n] = hold_d;
        n = n + 2'd1;
      end
      phase_d = PhNone;
    end
    bnd.cnt  = n;
    bnd.last = in_last_i;
  end

  assign push_o      = accept && (n != 2'd0);
  assign push_data_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_q  <= 1'b1;
      phase_q <= PhNone;
      hold_q  <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        plus_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        hold_q  <= hold_d;
      end
    end
  end

endmodule

@@ design/ped_queue.sv @@
// ----------------------------------------------------------------------------
// ped_queue
// Short queue of decoded bundles between the front and the back.
// ----------------------------------------------------------------------------
module ped_queue #(
  parameter int unsigned Depth = ped_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ped_pkg::ped_bundle_t push_data_i,
  input  logic                 pop_i,
  output ped_pkg::ped_bundle_t head_o,
  output ped_pkg::ped_qstat_t  stat_o
);
  import ped_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ped_bundle_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("bundle pushed into a full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

@@ design/ped_back.sv @@
// ----------------------------------------------------------------------------
// ped_back
// Walks the bundle at the head of the queue one byte per cycle into the
// output register, while that register is empty or its byte is being taken.
// ----------------------------------------------------------------------------
module ped_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ped_pkg::ped_bundle_t head_i,
  input  ped_pkg::ped_qstat_t  qstat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);
  import ped_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_free, take, at_end;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = out_free && !qstat_i.empty;
  assign at_end   = (idx_q == head_i.cnt - 2'd1);
  assign pop_o    = take && at_end;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_free) begin
      out_valid_d = !qstat_i.empty;
    end
    if (take) begin
      out_byte_d = head_i.bytes[idx_q];
      out_last_d = head_i.last && at_end;
      idx_d      = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_head_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat_i.empty |-> (head_i.cnt != 2'd0))
    else $error("empty bundle reached the back");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat_i.empty |-> (idx_q < head_i.cnt))
    else $error("byte index beyond bundle count");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_i.empty |-> (idx_q == 2'd0))
    else $error("byte index left mid-bundle with an empty queue");
`endif

endmodule

@@ design/percent_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// percent_escape_decoder
// URL percent decoding of a byte stream with optional plus-to-space.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the encoded string one byte per item, tlast
//   on the final byte. The master stream carries decoded bytes, tlast on
//   the final decoded byte of each string. cfg_we_i writes the plus mode
//   (1 turns '+' into a space); write it only while the block is idle.
//   The first byte an accepted item releases passes through the bundle
//   queue and then the output register before it is valid on the master
//   side. The front takes one item per cycle while the bundle queue has
//   room; the back sends one byte per cycle while m_axis_tready allows,
//   so an item that releases two or three bytes holds the back until all
//   of them are sent, and a run of such items fills the queue and drops
//   s_axis_tready. A stall on m_axis_tready holds the output register,
//   then the queue, then the slave side. Reset empties the queue and the
//   output register, clears any pending escape and sets the plus mode to 1.
// ----------------------------------------------------------------------------
module percent_escape_decoder #(
  parameter int unsigned QueueDepth = ped_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // plus_as_space
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic       m_axis_tlast
);
  import ped_pkg::*;

  ped_qstat_t  qstat;
  ped_bundle_t push_data, head;
  logic        push, pop;

  ped_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ped_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  ped_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
